### hw/rtl/cpd_pkg.sv
// Shared types and constants for the cyclic progression detector.
// No dependencies; imported by cpd_ctrl, cpd_datapath and the top level.
package cpd_pkg;

   // Width of each configuration register and of the loop counters.
   localparam int CFG_W = 6;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_MODULUS  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_PROG_LEN = 1'b1;

   typedef logic [CFG_W-1:0] cfg_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;          // capture a new item
      logic count_step;    // add the members of one byte of the mask
      logic init_d;        // start the first common difference
      logic scan_step;     // one rotate-and-AND
      logic next_d;        // move on to the next common difference
      logic set_result;    // record the answer
      logic result_value;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic chunk_last;    // last byte of the member count
      logic early_zero;    // small modulus, zero length or too few members
      logic starts_nz;     // running AND still has members
      logic i_lt_len;      // more terms remain for this difference
      logic d_last;        // current difference is the last one
   } dp_status_type;

endpackage

### hw/rtl/cpd_datapath.sv
// Datapath of the cyclic progression detector: mask, member count, rotator and loop counters.
// Depends on cpd_pkg; driven by commands from cpd_ctrl.
module cpd_datapath #(
   parameter int MASK_BITS = 63
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [MASK_BITS-1:0]   set_mask,
   input  cpd_pkg::cfg_type       modulus,
   input  cpd_pkg::cfg_type       prog_len,
   input  cpd_pkg::dp_cmd_type    cmd,
   output cpd_pkg::dp_status_type status,
   output logic                   result
);
   import cpd_pkg::*;

   localparam int NCHUNK = (MASK_BITS + 7) / 8;
   localparam int CHW    = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
   localparam int CW     = $clog2(MASK_BITS + 1);

   logic [MASK_BITS-1:0] mask_ff, mask_in;
   logic [MASK_BITS-1:0] starts_ff, starts_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [CHW-1:0]       chunk_ff, chunk_in;
   cfg_type              d_ff, d_in;
   cfg_type              i_ff, i_in;
   cfg_type              amt_ff, amt_in;
   logic                 result_ff, result_in;

   cfg_type              p_eff;
   cfg_type              halfp;
   logic [MASK_BITS-1:0] all_mask;
   logic [MASK_BITS-1:0] rot_left, rot_right, rot;
   logic [NCHUNK*8-1:0]  mask_pad;
   logic [7:0]           chunk_bits;
   logic [3:0]           chunk_pc;
   logic [CFG_W:0]       amt_sum;
   cfg_type              amt_next;

   // A modulus beyond the mask width is taken as the mask width.
   assign p_eff = (modulus > CFG_W'(MASK_BITS)) ? CFG_W'(MASK_BITS) : modulus;
   assign halfp = (p_eff - 1'b1) >> 1;

   always_comb begin
      for (int k = 0; k < MASK_BITS; k++) begin
         all_mask[k] = (CFG_W'(k) < p_eff);
      end
   end

   // Cyclic rotation of the low p bits; an amount of zero leaves the mask unchanged.
   assign rot_left  = mask_ff << amt_ff;
   assign rot_right = mask_ff >> (p_eff - amt_ff);
   assign rot       = (rot_left | rot_right) & all_mask;

   assign mask_pad   = (NCHUNK*8)'(mask_ff);
   assign chunk_bits = mask_pad[{chunk_ff, 3'b000} +: 8];

   always_comb begin
      chunk_pc = '0;
      for (int k = 0; k < 8; k++) begin
         chunk_pc = chunk_pc + 4'(chunk_bits[k]);
      end
   end

   assign amt_sum  = {1'b0, amt_ff} + {1'b0, d_ff};
   assign amt_next = (amt_sum >= {1'b0, p_eff}) ? CFG_W'(amt_sum - {1'b0, p_eff})
                                                 : CFG_W'(amt_sum);

   always_comb begin
      mask_in   = mask_ff;
      starts_in = starts_ff;
      cnt_in    = cnt_ff;
      chunk_in  = chunk_ff;
      d_in      = d_ff;
      i_in      = i_ff;
      amt_in    = amt_ff;
      result_in = result_ff;
      if (cmd.load) begin
         mask_in  = set_mask & all_mask;
         cnt_in   = '0;
         chunk_in = '0;
      end
      if (cmd.count_step) begin
         cnt_in   = cnt_ff + CW'(chunk_pc);
         chunk_in = chunk_ff + 1'b1;
      end
      if (cmd.init_d) begin
         d_in      = CFG_W'(1);
         amt_in    = CFG_W'(1);
         i_in      = CFG_W'(1);
         starts_in = mask_ff;
      end
      if (cmd.scan_step) begin
         starts_in = starts_ff & rot;
         amt_in    = amt_next;
         i_in      = i_ff + 1'b1;
      end
      if (cmd.next_d) begin
         d_in      = d_ff + 1'b1;
         amt_in    = d_ff + 1'b1;
         i_in      = CFG_W'(1);
         starts_in = mask_ff;
      end
      if (cmd.set_result) begin
         result_in = cmd.result_value;
      end
   end

   always_ff @(posedge clock) begin
      mask_ff   <= mask_in;
      starts_ff <= starts_in;
      cnt_ff    <= cnt_in;
      chunk_ff  <= chunk_in;
      d_ff      <= d_in;
      i_ff      <= i_in;
      amt_ff    <= amt_in;
      result_ff <= result_in;
   end

   assign status.chunk_last = (chunk_ff == CHW'(NCHUNK - 1));
   assign status.early_zero = (p_eff < CFG_W'(3)) || (prog_len == '0) ||
                              ((CFG_W+1)'(cnt_ff) < (CFG_W+1)'(prog_len));
   assign status.starts_nz  = (starts_ff != '0);
   assign status.i_lt_len   = (i_ff < prog_len);
   assign status.d_last     = (d_ff == halfp);
   assign result            = result_ff;

   // A rotate-and-AND can only remove candidate starting points.
   a_starts_shrink: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_step |=> ((starts_ff & ~$past(starts_ff)) == '0))
      else $error("running AND gained members");

   // The rotation amount stays a residue of the modulus.
   a_amt_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.scan_step || cmd.init_d || cmd.next_d) && !status.early_zero
      |=> (amt_ff < p_eff))
      else $error("rotation amount out of range");

   // The member count never decreases while counting and never exceeds the mask width.
   a_cnt_mono: assert property (@(posedge clock) disable iff (reset)
      cmd.count_step |=> (cnt_ff >= $past(cnt_ff)) && (cnt_ff <= CW'(MASK_BITS)))
      else $error("member count went wrong");

endmodule

### hw/rtl/cpd_ctrl.sv
// Controller state machine of the cyclic progression detector.
// Depends on cpd_pkg; issues commands to cpd_datapath and loads the result register.
module cpd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   out_free,
   input  cpd_pkg::dp_status_type status,
   output logic                   req_stall,
   output cpd_pkg::dp_cmd_type    cmd,
   output logic                   out_load
);
   import cpd_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_COUNT  = 3'd1;
   localparam logic [2:0] S_CHECK  = 3'd2;
   localparam logic [2:0] S_SCAN   = 3'd3;
   localparam logic [2:0] S_FINISH = 3'd4;

   logic [2:0] state_ff, state_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      out_load = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_COUNT;
            end
         end
         S_COUNT: begin
            cmd.count_step = 1'b1;
            if (status.chunk_last) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (status.early_zero) begin
               cmd.set_result   = 1'b1;
               cmd.result_value = 1'b0;
               state_in         = S_FINISH;
            end else begin
               cmd.init_d = 1'b1;
               state_in   = S_SCAN;
            end
         end
         S_SCAN: begin
            if (status.i_lt_len && status.starts_nz) begin
               cmd.scan_step = 1'b1;
            end else if (status.starts_nz) begin
               cmd.set_result   = 1'b1;
               cmd.result_value = 1'b1;
               state_in         = S_FINISH;
            end else if (status.d_last) begin
               cmd.set_result   = 1'b1;
               cmd.result_value = 1'b0;
               state_in         = S_FINISH;
            end else begin
               cmd.next_d = 1'b1;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### hw/rtl/cyclic_progression_detector_unit.sv
// Cyclic progression detector top level: configuration registers, output register, controller, datapath.
// Operation: the item is accepted, its members are counted one byte at a time, a check follows, then per
// difference up to (length-1) rotate-and-AND steps and one closing step, over up to (p-1)/2 differences,
// then the result goes to the output register; one item at a time, with the single rotator.
// A new item is accepted while the previous result waits in the output register.
// Synchronous reset clears control state and sets modulus to 3 and length to 0.
module cyclic_progression_detector_unit #(
   parameter int MASK_BITS = 63
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [MASK_BITS-1:0]            req_set_mask,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_has_progression,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [cpd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [cpd_pkg::CFG_W-1:0]       csr_wdata
);
   import cpd_pkg::*;

   cfg_type       modulus_ff, modulus_in;
   cfg_type       prog_len_ff, prog_len_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_data_ff, rsp_data_in;
   logic          out_free;
   logic          out_load;
   logic          result;
   dp_cmd_type    cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   always_comb begin
      modulus_in  = modulus_ff;
      prog_len_in = prog_len_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_MODULUS:  modulus_in  = csr_wdata;
            CSR_PROG_LEN: prog_len_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = out_load ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);
   assign rsp_data_in  = out_load ? result : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff   <= CFG_W'(3);
         prog_len_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         modulus_ff   <= modulus_in;
         prog_len_ff  <= prog_len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_has_progression = rsp_data_ff;

   cpd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .out_free  (out_free),
      .status    (status),
      .req_stall (req_stall),
      .cmd       (cmd),
      .out_load  (out_load)
   );

   cpd_datapath #(
      .MASK_BITS (MASK_BITS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .set_mask (req_set_mask),
      .modulus  (modulus_ff),
      .prog_len (prog_len_ff),
      .cmd      (cmd),
      .status   (status),
      .result   (result)
   );

endmodule
